### src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and constants shared by the bitmap page allocator modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int LIMIT_W     = 13;
  localparam int LIMIT_MAX   = (1 << LIMIT_W) - 1;
  localparam int LIMIT_RESET = 4096;
  localparam int PAGE_W      = 12;
  localparam int SEG_W       = 2;
  localparam int STATUS_W    = 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [SEG_W-1:0]  segment;
    logic [PAGE_W-1:0] page_number;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   page_number_res;
    logic [STATUS_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic clear_wr;
    logic start;
    logic advance;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic resolve;
  } ctl_sts_t;

endpackage

### src/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over one used/free bitmap per segment.
// ----------------------------------------------------------------------------
// Request channel (req_valid, req_stall, req) carries kind, segment and
// page_number; a transfer happens when req_valid is high and req_stall low.
// Allocate returns the lowest free page below page_limit and marks it used;
// free clears the page's bit. Result channel (res_valid, res_stall, res)
// carries page_number_res and status, held while res_stall is high.
// cfg_valid/cfg_ready write page_limit; cfg_ready is always high.
// Each request scans one bitmap word per cycle from the segment's first word.
// An allocate reads words up to the one holding the free page or the limit
// (at most PAGES/WORD_BITS, 128 by default); a free reads up to the word
// holding page_number; a bad segment or a free out of range stops at the
// first word. Commit registers the result and writes back the updated word.
// A new request is taken once the scan is done, while the result waits.
// A stalled result holds the scan of the next request at its final word.
// After reset a clearing pass writes SEGMENTS*PAGES/WORD_BITS words (512 by
// default), one per cycle, before the first request is taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGES     = 4096,
  parameter int SEGMENTS  = 4,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_datapath #(
    .PAGES     (PAGES),
    .SEGMENTS  (SEGMENTS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res       (res)
  );

endmodule

### src/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer: clearing pass after reset, request transfer, word scan and
// result register handshake.
// ----------------------------------------------------------------------------
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  output logic     res_valid,
  input  logic     res_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       res_valid_next;
  logic       out_free;

  assign out_free  = !res_valid || !res_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.resolve) begin
          cmd.advance = 1'b1;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    res_valid_next = cmd.commit || (res_valid && res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

### src/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// Bitmap memory, page limit register, word scan counters, first-free search
// and result register.
// ----------------------------------------------------------------------------
module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int PAGES     = 4096,
  parameter int SEGMENTS  = 4,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output ctl_sts_t           sts,
  input  req_t               req,
  input  logic               cfg_valid,
  input  logic [LIMIT_W-1:0] cfg_data,
  output res_t               res
);

  localparam int WPS   = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int TOTAL = SEGMENTS * WPS;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int WIW   = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int BIW   = $clog2(WORD_BITS);
  localparam int PCW   = $clog2(LIMIT_MAX + WORD_BITS + 1);

  logic [WORD_BITS-1:0] mem [TOTAL];
  logic [WORD_BITS-1:0] rdata;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;

  logic [LIMIT_W-1:0]   page_limit;
  logic [AW-1:0]        clr_cnt;
  logic [AW-1:0]        base;
  logic [WIW-1:0]       wi;
  logic [PCW-1:0]       bp;
  logic                 kind;
  logic [SEG_W-1:0]     seg;
  logic [PAGE_W-1:0]    pn;

  logic [LIMIT_W-1:0]   lim;
  logic [PCW-1:0]       lim_ext;
  logic [PCW-1:0]       pn_ext;
  logic [PCW-1:0]       bp_end;
  logic [PCW-1:0]       rem;
  logic [AW-1:0]        base_in;
  logic [AW-1:0]        cur_addr;
  logic [WORD_BITS-1:0] avail;
  logic [BIW-1:0]       idx;
  logic [BIW-1:0]       off;
  logic                 any;
  logic                 bad_seg;
  logic                 free_range;
  logic                 last;
  logic                 hit;
  logic                 upd;
  logic [WORD_BITS-1:0] upd_word;
  res_t                 res_next;

  assign lim     = (32'(page_limit) > PAGES) ? LIMIT_W'(PAGES) : page_limit;
  assign lim_ext = PCW'(lim);
  assign pn_ext  = PCW'(pn);
  assign bp_end  = bp + PCW'(WORD_BITS);
  assign rem     = (lim_ext > bp) ? (lim_ext - bp) : '0;
  assign base_in = AW'(32'(req.segment) * WPS);
  assign cur_addr = AW'((AW + 1)'(base) + (AW + 1)'(wi));

  assign bad_seg    = (32'(seg) >= SEGMENTS);
  assign free_range = (PCW'(pn) >= lim_ext);
  assign last       = (bp_end >= lim_ext);
  assign hit        = (pn_ext < bp_end);
  assign off        = BIW'(pn_ext - bp);

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      avail[j] = !rdata[j] && (PCW'(j) < rem);
    end
    idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        idx = BIW'(j);
      end
    end
    any = |avail;
  end

  always_comb begin
    sts.clear_last       = (clr_cnt == AW'(TOTAL - 1));
    sts.resolve          = 1'b0;
    upd                  = 1'b0;
    upd_word             = rdata;
    res_next.page_number_res = '0;
    res_next.status      = ST_OK;
    if (bad_seg) begin
      sts.resolve     = 1'b1;
      res_next.status = ST_RANGE;
    end else if (kind == KIND_FREE) begin
      if (free_range) begin
        sts.resolve     = 1'b1;
        res_next.status = ST_RANGE;
      end else if (hit) begin
        sts.resolve = 1'b1;
        upd         = 1'b1;
        upd_word    = rdata & ~(WORD_BITS'(1) << off);
      end
    end else begin
      if (any) begin
        sts.resolve              = 1'b1;
        upd                      = 1'b1;
        upd_word                 = rdata | (WORD_BITS'(1) << idx);
        res_next.page_number_res = PAGE_W'(bp + PCW'(idx));
      end else if (last) begin
        sts.resolve     = 1'b1;
        res_next.status = ST_NO_FREE;
      end
    end
  end

  always_comb begin
    if (cmd.start) begin
      raddr = base_in;
    end else if (cmd.advance) begin
      raddr = AW'((AW + 1)'(cur_addr) + (AW + 1)'(1));
    end else begin
      raddr = cur_addr;
    end
    if (cmd.clear_wr) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else begin
      we    = cmd.commit && upd;
      waddr = cur_addr;
      wdata = upd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= LIMIT_W'(LIMIT_RESET);
      clr_cnt    <= '0;
    end else begin
      if (cfg_valid) begin
        page_limit <= cfg_data;
      end
      if (cmd.clear_wr) begin
        clr_cnt <= AW'((AW + 1)'(clr_cnt) + (AW + 1)'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind <= req.kind;
      seg  <= req.segment;
      pn   <= req.page_number;
      base <= base_in;
      wi   <= '0;
      bp   <= '0;
    end else if (cmd.advance) begin
      wi <= wi + WIW'(1);
      bp <= bp_end;
    end
    if (cmd.commit) begin
      res <= res_next;
    end
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit bitmap page allocator.
// ----------------------------------------------------------------------------
// A table of directed requests and limit writes runs first: reset state,
// zero and unit limits, a limit above the page count, frees of free pages
// and frees out of range. Random phases follow, each under its own page
// limit, with allocates, frees up to the top page allocated and random frees.
// A bitmap model predicts results the table leaves open. Both channels idle and
// stall at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb;
  import bpa_pkg::*;

  localparam int NUM_SEG   = 4;
  localparam int NUM_PAGES = 4096;
  localparam int PHASE_ITEMS = 175;

  typedef struct {
    bit   is_cfg;
    int   limit;
    req_t rq;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  req_t               req;
  logic               res_valid;
  logic               res_stall;
  res_t               res;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  bit   used_map [NUM_SEG][NUM_PAGES];
  int   high_page [NUM_SEG];
  int   cur_limit;
  res_t pending_results[$];
  dir_row_t stim_table[$];
  bit   steady;
  int   err_count;
  int   n_sent;
  int   n_limits;
  int   n_ok;
  int   n_no_free;
  int   n_range;
  int   peak_page;
  int   phase_limits [10] = '{4096, 37, 1, 8191, 260, 0, 4095, 64, 1000, 4096};

  bitmap_page_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic res_t predict_page_op(input req_t r);
    res_t o;
    int   lim;
    bit   found;
    o.page_number_res = '0;
    o.status = ST_OK;
    lim = (cur_limit > NUM_PAGES) ? NUM_PAGES : cur_limit;
    found = 1'b0;
    if (r.kind == KIND_ALLOC) begin
      o.status = ST_NO_FREE;
      for (int p = 0; p < lim; p++) begin
        if (!found && !used_map[r.segment][p]) begin
          found = 1'b1;
          used_map[r.segment][p] = 1'b1;
          o.page_number_res = p[PAGE_W-1:0];
          o.status = ST_OK;
          if (p > high_page[r.segment]) high_page[r.segment] = p;
        end
      end
    end else if (int'(r.page_number) >= lim) begin
      o.status = ST_RANGE;
    end else begin
      used_map[r.segment][r.page_number] = 1'b0;
    end
    return o;
  endfunction

  function automatic void add_cfg_row(input int limit);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.limit = limit;
    row.rq = '0;
    row.typed = 1'b0;
    row.want = '0;
    stim_table.push_back(row);
  endfunction

  function automatic void add_req_row(input logic kind, input int seg, input int pg,
                                      input bit typed, input int want_pg,
                                      input logic [STATUS_W-1:0] want_st);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.limit = 0;
    row.rq.kind = kind;
    row.rq.segment = seg[SEG_W-1:0];
    row.rq.page_number = pg[PAGE_W-1:0];
    row.typed = typed;
    row.want.page_number_res = want_pg[PAGE_W-1:0];
    row.want.status = want_st;
    stim_table.push_back(row);
  endfunction

  task automatic wait_drain();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data <= v[LIMIT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = v & LIMIT_MAX;
    n_limits++;
  endtask

  task automatic send_req(input req_t r, input bit typed, input res_t want);
    int   gap;
    res_t pred;
    if ($urandom_range(0, 49) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = predict_page_op(r);
    pending_results.push_back(typed ? want : pred);
    n_sent++;
  endtask

  function automatic req_t pick_request();
    req_t r;
    int   seg;
    int   c;
    seg = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, NUM_SEG - 1);
    c = $urandom_range(0, 99);
    r.segment = seg[SEG_W-1:0];
    r.page_number = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
    if (c < 55) begin
      r.kind = KIND_ALLOC;
    end else if (c < 85) begin
      r.kind = KIND_FREE;
      r.page_number = PAGE_W'($urandom_range(0, high_page[seg]));
    end else begin
      r.kind = KIND_FREE;
    end
    return r;
  endfunction

  initial begin : result_side
    int   hold;
    res_t want;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid === 1'b1 && !res_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result page %0d status %0d",
                                    res.page_number_res, res.status));
        end else begin
          want = pending_results.pop_front();
          if (res.page_number_res !== want.page_number_res) begin
            report_mismatch($sformatf("page_number_res %0h, expected %0h",
                                      res.page_number_res, want.page_number_res));
          end
          if (res.status !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      res.status, want.status));
          end
          if (want.status == ST_OK) n_ok++;
          if (want.status == ST_NO_FREE) n_no_free++;
          if (want.status == ST_RANGE) n_range++;
          if (int'(want.page_number_res) > peak_page) begin
            peak_page = int'(want.page_number_res);
          end
        end
        hold = steady ? 0 : $urandom_range(0, 11);
        if (hold > 0) begin
          res_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          res_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : request_side
    res_t none;
    none = '0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    cur_limit = LIMIT_RESET;
    for (int s = 0; s < NUM_SEG; s++) begin
      high_page[s] = 0;
      for (int p = 0; p < NUM_PAGES; p++) used_map[s][p] = 1'b0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_req_row(KIND_ALLOC, 0, 0,    1, 0, ST_OK);
    add_req_row(KIND_ALLOC, 0, 4095, 1, 1, ST_OK);
    add_req_row(KIND_ALLOC, 3, 0,    1, 0, ST_OK);
    add_req_row(KIND_FREE,  0, 4095, 1, 0, ST_OK);
    add_req_row(KIND_FREE,  0, 0,    1, 0, ST_OK);
    add_req_row(KIND_ALLOC, 0, 0,    1, 0, ST_OK);
    add_cfg_row(4096);
    add_req_row(KIND_ALLOC, 1, 0,    0, 0, ST_OK);
    add_cfg_row(0);
    add_req_row(KIND_ALLOC, 1, 0,    1, 0, ST_NO_FREE);
    add_req_row(KIND_FREE,  1, 0,    1, 0, ST_RANGE);
    add_cfg_row(1);
    add_req_row(KIND_ALLOC, 2, 0,    1, 0, ST_OK);
    add_req_row(KIND_ALLOC, 2, 0,    1, 0, ST_NO_FREE);
    add_req_row(KIND_FREE,  2, 1,    1, 0, ST_RANGE);
    add_req_row(KIND_FREE,  2, 0,    1, 0, ST_OK);
    add_cfg_row(LIMIT_MAX);
    add_req_row(KIND_ALLOC, 2, 0,    1, 0, ST_OK);
    add_req_row(KIND_FREE,  3, 4095, 1, 0, ST_OK);
    add_req_row(KIND_ALLOC, 0, 0,    0, 0, ST_OK);
    add_req_row(KIND_FREE,  1, 2730, 0, 0, ST_OK);
    add_req_row(KIND_FREE,  1, 1365, 0, 0, ST_OK);
    add_cfg_row(2);
    add_req_row(KIND_ALLOC, 0, 0,    1, 0, ST_NO_FREE);
    add_req_row(KIND_FREE,  0, 2,    1, 0, ST_RANGE);
    add_req_row(KIND_FREE,  0, 1,    1, 0, ST_OK);
    add_req_row(KIND_ALLOC, 0, 0,    0, 0, ST_OK);

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        write_limit(stim_table[i].limit);
      end else begin
        send_req(stim_table[i].rq, stim_table[i].typed, stim_table[i].want);
      end
    end

    foreach (phase_limits[ph]) begin
      write_limit(phase_limits[ph]);
      repeat (PHASE_ITEMS) send_req(pick_request(), 1'b0, none);
    end

    wait_drain();
    repeat (150) @(posedge clk);
    while (pending_results.size() != 0) begin
      void'(pending_results.pop_front());
      report_mismatch("expected result never arrived");
    end

    $display("Ran %0d requests under %0d limit writes, zero to full width.",
             n_sent, n_limits);
    $display("Results: %0d ok, %0d no free page, %0d out of range; top page %0d.",
             n_ok, n_no_free, n_range, peak_page);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
